@@ rtl/spot_aim_pkg.sv @@
// ----------------------------------------------------------------------------
// spot_aim_pkg
// Shared types and constants of the spotlight aiming pipeline.
// ----------------------------------------------------------------------------
package spot_aim_pkg;

    // widest coordinate carried between stages
    localparam int COORD_W = 8;

    // CORDIC sizing
    localparam int CORDIC_ITERS     = 44;
    localparam int CORDIC_FRAC_BITS = 40;
    localparam int CORDIC_GUARD     = 32;

    // pan selection codes
    localparam logic [2:0] PAN_UP    = 3'd0;
    localparam logic [2:0] PAN_DOWN  = 3'd1;
    localparam logic [2:0] PAN_LEVEL = 3'd2;
    localparam logic [2:0] PAN_FULL  = 3'd3;
    localparam logic [2:0] PAN_ZERO  = 3'd4;

    // tilt selection codes
    localparam logic [1:0] TILT_ANG   = 2'd0;
    localparam logic [1:0] TILT_ZERO  = 2'd1;
    localparam logic [1:0] TILT_RIGHT = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SENSOR_XS    = 3'd0;
    localparam logic [2:0] REG_SENSOR_YS    = 3'd1;
    localparam logic [2:0] REG_LIGHT_A_X    = 3'd2;
    localparam logic [2:0] REG_LIGHT_A_Y    = 3'd3;
    localparam logic [2:0] REG_LIGHT_B_X    = 3'd4;
    localparam logic [2:0] REG_LIGHT_B_Y    = 3'd5;
    localparam logic [2:0] REG_LIGHT_HEIGHT = 3'd6;

    typedef struct packed {
        logic               has;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [2:0]         cnt;
    } cent_t;

    typedef struct packed {
        logic               has;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [2:0]         cnt;
        logic [2:0]         pan_a_mode;
        logic [1:0]         tilt_a_mode;
        logic [2:0]         pan_b_mode;
        logic [1:0]         tilt_b_mode;
    } side_t;

endpackage

@@ rtl/spot_aim_centroid.sv @@
// ----------------------------------------------------------------------------
// spot_aim_centroid
// Three-stage centroid: masked sums and count, reciprocal multiply, shift.
// ----------------------------------------------------------------------------
module spot_aim_centroid #(
    parameter int NUM_SENSORS = 6,
    parameter int COORD_BITS  = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [5:0]                 mask,
    input  logic [47:0]                sensor_xs,
    input  logic [47:0]                sensor_ys,
    output logic                       out_valid,
    output spot_aim_pkg::cent_t        out_cent
);

    localparam int SW = COORD_BITS + 3;
    localparam int RS = 18;
    localparam int RW = RS + 1;
    localparam int PW = SW + RW;

    logic          v1_reg, v2_reg, v3_reg;
    logic [SW-1:0] sx_reg, sy_reg;
    logic [2:0]    cnt1_reg, cnt2_reg;
    logic [PW-1:0] prx_reg, pry_reg;
    spot_aim_pkg::cent_t cent_reg;

    logic [SW-1:0] sx_next, sy_next;
    logic [2:0]    cnt_next;
    logic [RW-1:0] recip;

    always_comb begin
        sx_next  = '0;
        sy_next  = '0;
        cnt_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (mask[i]) begin
                sx_next  = sx_next + SW'(sensor_xs[8*i +: COORD_BITS]);
                sy_next  = sy_next + SW'(sensor_ys[8*i +: COORD_BITS]);
                cnt_next = cnt_next + 3'd1;
            end
        end
    end

    // ceil(2^18 / n), exact for every sum that six coordinates can reach
    always_comb begin
        unique case (cnt1_reg)
            3'd1:    recip = RW'(262144);
            3'd2:    recip = RW'(131072);
            3'd3:    recip = RW'(87382);
            3'd4:    recip = RW'(65536);
            3'd5:    recip = RW'(52429);
            3'd6:    recip = RW'(43691);
            default: recip = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            cnt1_reg     <= cnt_next;
            prx_reg      <= PW'(sx_reg) * PW'(recip);
            pry_reg      <= PW'(sy_reg) * PW'(recip);
            cnt2_reg     <= cnt1_reg;
            cent_reg.has <= (cnt2_reg != 3'd0);
            cent_reg.px  <= spot_aim_pkg::COORD_W'(prx_reg[RS +: COORD_BITS]);
            cent_reg.py  <= spot_aim_pkg::COORD_W'(pry_reg[RS +: COORD_BITS]);
            cent_reg.cnt <= cnt2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_cent  = cent_reg;

endmodule

@@ rtl/spot_aim_cordic.sv @@
// ----------------------------------------------------------------------------
// spot_aim_cordic
// Pipelined vectoring CORDIC: atan(y/x) in degrees, rounded to the angle LSB.
// ----------------------------------------------------------------------------
module spot_aim_cordic #(
    parameter int AFB = 8
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [spot_aim_pkg::COORD_W-1:0]  x_in,
    input  logic [spot_aim_pkg::COORD_W-1:0]  y_in,
    output logic [AFB+6:0]                    ang_out
);

    localparam int N  = spot_aim_pkg::CORDIC_ITERS;
    localparam int FB = spot_aim_pkg::CORDIC_FRAC_BITS;
    localparam int G  = spot_aim_pkg::CORDIC_GUARD;
    // x grows by the CORDIC gain times sqrt(2): room for 255 * 1.65 * 1.42
    localparam int XW = spot_aim_pkg::COORD_W + FB + 3;
    localparam int ZW = AFB + G + 8;
    localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << (G - 1));

    // atan(2^-k) in units of 2^-(AFB+G) degree
    function automatic logic signed [ZW-1:0] step_angle(input int k);
        real a;
        a = $atan(2.0 ** (-k)) * 57.29577951308232 * (2.0 ** (AFB + G));
        return ZW'(longint'(a));
    endfunction

    logic signed [XW-1:0] x_reg [N];
    logic signed [XW-1:0] y_reg [N];
    logic signed [ZW-1:0] z_reg [N];
    logic signed [XW-1:0] x0, y0;
    logic signed [ZW-1:0] z_rnd;

    assign x0 = signed'({3'b000, x_in, FB'(0)});
    assign y0 = signed'({3'b000, y_in, FB'(0)});

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = step_angle(k);
        logic signed [XW-1:0] xi, yi;
        logic signed [ZW-1:0] zi;
        if (k == 0) begin : g_first
            assign xi = x0;
            assign yi = y0;
            assign zi = '0;
        end else begin : g_rest
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!yi[XW-1]) begin
                    x_reg[k] <= xi + (yi >>> k);
                    y_reg[k] <= yi - (xi >>> k);
                    z_reg[k] <= zi + ANG;
                end else begin
                    x_reg[k] <= xi - (yi >>> k);
                    y_reg[k] <= yi + (xi >>> k);
                    z_reg[k] <= zi - ANG;
                end
            end
        end
    end

    assign z_rnd   = z_reg[N-1] + HALF;
    assign ang_out = z_rnd[G +: AFB+7];

endmodule

@@ rtl/spotlight_aim_from_sensor_mask_core.sv @@
// ----------------------------------------------------------------------------
// spotlight_aim_from_sensor_mask_core
// Person centroid from a floor sensor mask, pan and tilt for two lights.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side: one word per sensor mask, tdata[5:0] = sensor_mask.
//   m_ side: one word per mask: valid_person, centroid, count, and
//   pan/tilt of both lights in 1/2^ANGLE_FRAC_BITS degree.
//   cfg port: write enable, register index, 48-bit data; write only while
//   the pipeline is empty.
// Throughput: one word per cycle unless the output stalls. Pipeline: 3 centroid
//   stages, 44 CORDIC iterations and one output stage between acceptance and
//   m_tvalid; its depth is set by the CORDIC iteration count.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
//   s_tready drops in the same cycle, so nothing is lost or repeated.
// Reset: aresetn low clears every valid bit and restores register defaults.
//   No clearing pass.
// No active sensor: valid_person and every other field come out zero.
// ----------------------------------------------------------------------------
module spotlight_aim_from_sensor_mask_core #(
    parameter int NUM_SENSORS     = 6,
    parameter int COORD_BITS      = 8,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [5:0] sensor_mask, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    // valid_person, person_x, person_y, active_count, pan_a, tilt_a,
    // pan_b, tilt_b, zero pad
    output logic [((50 + 4*ANGLE_FRAC_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata
);

    localparam int AFB    = ANGLE_FRAC_BITS;
    localparam int PANW   = AFB + 8;
    localparam int TILTW  = AFB + 7;
    localparam int N      = spot_aim_pkg::CORDIC_ITERS;
    localparam int CW     = spot_aim_pkg::COORD_W;
    localparam int FIELDW = 20 + 2 * (PANW + TILTW);
    localparam int DATA_W = ((FIELDW + 7) / 8) * 8;
    localparam logic [PANW-1:0] DEG90  = PANW'(90 << AFB);
    localparam logic [PANW-1:0] DEG180 = PANW'(180 << AFB);
    // light coordinates and height count in their low COORD_BITS bits
    localparam logic [CW-1:0]   CMASK  = CW'((1 << COORD_BITS) - 1);

    typedef struct packed {
        logic [2:0]    pan_mode;
        logic [CW-1:0] pan_x;
        logic [CW-1:0] pan_y;
        logic [1:0]    tilt_mode;
        logic [CW-1:0] tilt_x;
        logic [CW-1:0] tilt_y;
    } aim_t;

    // configuration
    logic [47:0]   sensor_xs_reg, sensor_ys_reg;
    logic [CW-1:0] lax_reg, lay_reg, lbx_reg, lby_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_xs_reg <= 48'h0B0907050301;
            sensor_ys_reg <= 48'h0C0A08060402;
            lax_reg       <= CW'(0);
            lay_reg       <= CW'(5);
            lbx_reg       <= CW'(20);
            lby_reg       <= CW'(5);
            height_reg    <= CW'(3);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                spot_aim_pkg::REG_SENSOR_XS:    sensor_xs_reg <= cfg_wdata;
                spot_aim_pkg::REG_SENSOR_YS:    sensor_ys_reg <= cfg_wdata;
                spot_aim_pkg::REG_LIGHT_A_X:    lax_reg       <= cfg_wdata[CW-1:0];
                spot_aim_pkg::REG_LIGHT_A_Y:    lay_reg       <= cfg_wdata[CW-1:0];
                spot_aim_pkg::REG_LIGHT_B_X:    lbx_reg       <= cfg_wdata[CW-1:0];
                spot_aim_pkg::REG_LIGHT_B_Y:    lby_reg       <= cfg_wdata[CW-1:0];
                spot_aim_pkg::REG_LIGHT_HEIGHT: height_reg    <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // one enable for every stage: advance unless the output word is stuck
    logic advance;
    logic m_tvalid_reg;
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // centroid stages
    logic                cent_valid;
    spot_aim_pkg::cent_t cent;

    spot_aim_centroid #(
        .NUM_SENSORS (NUM_SENSORS),
        .COORD_BITS  (COORD_BITS)
    ) u_centroid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (s_tvalid),
        .mask      (s_tdata[5:0]),
        .sensor_xs (sensor_xs_reg),
        .sensor_ys (sensor_ys_reg),
        .out_valid (cent_valid),
        .out_cent  (cent)
    );

    // pick CORDIC operands and the special case for one light
    function automatic aim_t aim_of(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                    input logic [CW-1:0] lx, input logic [CW-1:0] ly,
                                    input logic [CW-1:0] h);
        aim_t a;
        logic [CW-1:0] dx, dy;
        dx = (px >= lx) ? px - lx : lx - px;
        dy = (py >= ly) ? py - ly : ly - py;
        a.pan_x  = (dx == '0) ? CW'(1) : dx;
        a.pan_y  = dy;
        a.tilt_x = (h == '0) ? CW'(1) : h;
        a.tilt_y = dx;
        priority if (py == ly)   a.pan_mode = spot_aim_pkg::PAN_LEVEL;
        else if (dx == '0)       a.pan_mode = (py > ly) ? spot_aim_pkg::PAN_FULL
                                                        : spot_aim_pkg::PAN_ZERO;
        else if (py > ly)        a.pan_mode = spot_aim_pkg::PAN_UP;
        else                     a.pan_mode = spot_aim_pkg::PAN_DOWN;
        priority if (dx == '0)   a.tilt_mode = spot_aim_pkg::TILT_ZERO;
        else if (h == '0)        a.tilt_mode = spot_aim_pkg::TILT_RIGHT;
        else                     a.tilt_mode = spot_aim_pkg::TILT_ANG;
        return a;
    endfunction

    aim_t aim_a, aim_b;
    assign aim_a = aim_of(cent.px, cent.py, lax_reg & CMASK, lay_reg & CMASK,
                          height_reg & CMASK);
    assign aim_b = aim_of(cent.px, cent.py, lbx_reg & CMASK, lby_reg & CMASK,
                          height_reg & CMASK);

    // four angle pipelines
    logic [TILTW-1:0] ang_pan_a, ang_tilt_a, ang_pan_b, ang_tilt_b;

    spot_aim_cordic #(.AFB(AFB)) u_pan_a (
        .aclk(aclk), .en(advance), .x_in(aim_a.pan_x), .y_in(aim_a.pan_y),
        .ang_out(ang_pan_a));
    spot_aim_cordic #(.AFB(AFB)) u_tilt_a (
        .aclk(aclk), .en(advance), .x_in(aim_a.tilt_x), .y_in(aim_a.tilt_y),
        .ang_out(ang_tilt_a));
    spot_aim_cordic #(.AFB(AFB)) u_pan_b (
        .aclk(aclk), .en(advance), .x_in(aim_b.pan_x), .y_in(aim_b.pan_y),
        .ang_out(ang_pan_b));
    spot_aim_cordic #(.AFB(AFB)) u_tilt_b (
        .aclk(aclk), .en(advance), .x_in(aim_b.tilt_x), .y_in(aim_b.tilt_y),
        .ang_out(ang_tilt_b));

    // side line: carry centroid and case codes alongside the CORDIC stages
    logic                side_v_reg [N];
    spot_aim_pkg::side_t side_reg   [N];
    spot_aim_pkg::side_t side_in;

    always_comb begin
        side_in.has         = cent.has;
        side_in.px          = cent.px;
        side_in.py          = cent.py;
        side_in.cnt         = cent.cnt;
        side_in.pan_a_mode  = aim_a.pan_mode;
        side_in.tilt_a_mode = aim_a.tilt_mode;
        side_in.pan_b_mode  = aim_b.pan_mode;
        side_in.tilt_b_mode = aim_b.tilt_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) side_v_reg[k] <= 1'b0;
        end else if (advance) begin
            side_v_reg[0] <= cent_valid;
            for (int k = 1; k < N; k++) side_v_reg[k] <= side_v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < N; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    // final assembly
    function automatic logic [PANW-1:0] pan_val(input logic [2:0] mode,
                                                input logic [TILTW-1:0] ang);
        logic [PANW-1:0] r;
        unique case (mode)
            spot_aim_pkg::PAN_UP:    r = DEG90 + PANW'(ang);
            spot_aim_pkg::PAN_DOWN:  r = DEG90 - PANW'(ang);
            spot_aim_pkg::PAN_LEVEL: r = DEG90;
            spot_aim_pkg::PAN_FULL:  r = DEG180;
            default:                 r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [TILTW-1:0] tilt_val(input logic [1:0] mode,
                                                  input logic [TILTW-1:0] ang);
        logic [TILTW-1:0] r;
        unique case (mode)
            spot_aim_pkg::TILT_ANG:   r = ang;
            spot_aim_pkg::TILT_RIGHT: r = DEG90[TILTW-1:0];
            default:                  r = '0;
        endcase
        return r;
    endfunction

    spot_aim_pkg::side_t s;
    logic [DATA_W-1:0]   data_next, m_tdata_reg;

    assign s = side_reg[N-1];

    always_comb begin
        data_next = '0;
        if (s.has) begin
            data_next[FIELDW-1:0] = {tilt_val(s.tilt_b_mode, ang_tilt_b),
                                     pan_val(s.pan_b_mode, ang_pan_b),
                                     tilt_val(s.tilt_a_mode, ang_tilt_a),
                                     pan_val(s.pan_a_mode, ang_pan_a),
                                     s.cnt, s.py, s.px, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= side_v_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/spot_aim_checker.sv @@
// ----------------------------------------------------------------------------
// spot_aim_checker
// Port-level checks of the spotlight aiming block, bound to the top level.
// ----------------------------------------------------------------------------
module spot_aim_checker #(
    parameter int DATA_W = 88
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // input side advances with the output register
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    // no person: whole word zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[DATA_W-1:1] == '0)
        else $error("fields set with no active sensor");

    // person present: count nonzero
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[19:17] != 3'd0)
        else $error("person reported with zero count");

endmodule

bind spotlight_aim_from_sensor_mask_core spot_aim_checker #(.DATA_W(DATA_W)) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
